// ----- rtl/fas_pkg.sv -----
// Shared types and constants for the age queue with statistics.
`default_nettype none
package fas_pkg;

    localparam int AGE_W           = 10;
    localparam int MEAN_W          = 18;
    localparam int FRAC_W          = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [AGE_W-1:0] AGE_LIMIT = 10'd1000;
    localparam logic [AGE_W-1:0] AGE_MAX   = 10'd999;

    typedef enum logic [2:0] {
        MODE_ENQ   = 3'd0,
        MODE_DEQ   = 3'd1,
        MODE_MEAN  = 3'd2,
        MODE_MAX   = 3'd3,
        MODE_MIN   = 3'd4,
        MODE_RANGE = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DIV  = 2'd2,
        S_DONE = 2'd3
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/fifo_with_age_statistics.sv -----
// Top level: age queue with mean, maximum, minimum and range over stored words.
//
//  channel   dir  ports                     word contents (lsb first)
//  s_axis    in   tvalid tready tdata tuser  tdata: age[9:0]; tuser: mode[2:0]
//  m_axis    out  tvalid tready tdata tuser  tdata: value[9:0], mean_q8[27:10];
//                                            tuser: status[1:0]
//
// One request at a time. Enqueue, unused modes and empty-queue requests skip
// the scan. Dequeue reads the head entry; max/min/range scan every stored word,
// reading one store entry per cycle through the single read port. Mean scans
// too, then runs the bit-serial divider. Reset empties the queue; store contents
// are not cleared. A finished result waits in the output register while the
// next request is taken.
`default_nettype none
module fifo_with_age_statistics #(
    parameter int QUEUE_DEPTH = fas_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // age[9:0], zero pad
    input  wire logic [2:0]  i_s_axis_tuser,   // mode[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // value[9:0], mean_q8[27:10], zero pad
    output logic      [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = fas_pkg::AGE_W;
    localparam int SW = AW + CW;
    localparam int DW = SW + fas_pkg::FRAC_W;
    localparam int MW = fas_pkg::MEAN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

    fas_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_head, r_tail, r_slot;
    logic [CW-1:0] r_count, r_len, r_issue;
    logic          r_rvalid;
    logic [2:0]    r_mode;
    logic [SW-1:0] r_sum;
    logic [AW-1:0] r_max, r_min;
    logic [1:0]    r_res_status;
    logic [AW-1:0] r_res_value;
    logic [MW-1:0] r_res_mean;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [AW-1:0] r_out_value;
    logic [MW-1:0] r_out_mean;

    logic          accept, empty, full, issue, scan_fin, out_load;
    logic          ram_we, div_start, div_done;
    logic [2:0]    in_mode;
    logic [AW-1:0] in_age, sat_age, rdata;
    logic [MW-1:0] quot;

    assign in_mode = i_s_axis_tuser;
    assign in_age  = i_s_axis_tdata[AW-1:0];
    assign sat_age = (in_age >= fas_pkg::AGE_LIMIT) ? fas_pkg::AGE_MAX : in_age;
    assign empty   = (r_count == '0);
    assign full    = (r_count == DEPTH_C);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fas_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_mode inside {fas_pkg::MODE_DEQ, fas_pkg::MODE_MEAN,
                                        fas_pkg::MODE_MAX, fas_pkg::MODE_MIN,
                                        fas_pkg::MODE_RANGE} && !empty) begin
                        n_state = fas_pkg::S_SCAN;
                    end else begin
                        n_state = fas_pkg::S_DONE;
                    end
                end
            end
            fas_pkg::S_SCAN: begin
                if (scan_fin) begin
                    n_state = (r_mode == fas_pkg::MODE_MEAN) ? fas_pkg::S_DIV
                                                             : fas_pkg::S_DONE;
                end
            end
            fas_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = fas_pkg::S_DONE;
                end
            end
            fas_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = fas_pkg::S_IDLE;
                end
            end
            default: n_state = fas_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_axis_tready = (r_state == fas_pkg::S_IDLE);
        issue    = (r_state == fas_pkg::S_SCAN) && (r_issue != r_len);
        scan_fin = (r_state == fas_pkg::S_SCAN) && !issue && !r_rvalid;
        ram_we   = accept && (in_mode == fas_pkg::MODE_ENQ) && !full;
        div_start = scan_fin && (r_mode == fas_pkg::MODE_MEAN);
        out_load = (r_state == fas_pkg::S_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    fas_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (sat_age),
        .i_re    (issue),
        .i_raddr (r_slot),
        .o_rdata (rdata)
    );

    fas_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, {fas_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fas_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= issue;
            if (ram_we) begin
                r_tail  <= (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (scan_fin && r_mode == fas_pkg::MODE_DEQ) begin
                r_head  <= (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode       <= in_mode;
            r_slot       <= r_head;
            r_issue      <= '0;
            r_len        <= (in_mode == fas_pkg::MODE_DEQ) ? CW'(1) : r_count;
            r_sum        <= '0;
            r_max        <= '0;
            r_min        <= fas_pkg::AGE_LIMIT;
            r_res_value  <= '0;
            r_res_mean   <= '0;
            r_res_status <= fas_pkg::STAT_OK;
            if (in_mode == fas_pkg::MODE_ENQ) begin
                if (full) begin
                    r_res_status <= fas_pkg::STAT_FULL;
                end
            end else if (in_mode inside {fas_pkg::MODE_DEQ, fas_pkg::MODE_MEAN,
                                         fas_pkg::MODE_MAX, fas_pkg::MODE_MIN,
                                         fas_pkg::MODE_RANGE} && empty) begin
                r_res_status <= fas_pkg::STAT_EMPTY;
            end
        end
        if (issue) begin
            r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_issue <= r_issue + 1'b1;
        end
        if (r_rvalid) begin
            r_sum <= r_sum + SW'(rdata);
            if (rdata > r_max) r_max <= rdata;
            if (rdata < r_min) r_min <= rdata;
        end
        if (scan_fin) begin
            case (r_mode)
                fas_pkg::MODE_DEQ:   r_res_value <= r_max;
                fas_pkg::MODE_MAX:   r_res_value <= r_max;
                fas_pkg::MODE_MIN:   r_res_value <= r_min;
                fas_pkg::MODE_RANGE: r_res_value <= r_max - r_min;
                default:             r_res_value <= '0;
            endcase
        end
        if (div_done) begin
            r_res_mean <= quot;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_mean   <= r_res_mean;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(32 - AW - MW){1'b0}}, r_out_mean, r_out_value};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above queue depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fas_pkg::S_SCAN) |-> (r_count != '0))
        else $error("scan started on empty queue");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != fas_pkg::S_IDLE))
        else $error("request accepted without leaving idle");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == fas_pkg::S_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule
`default_nettype wire

// ----- rtl/fas_ram.sv -----
// Simple dual-port age store, one write and one registered read per cycle.
`default_nettype none
module fas_ram #(
    parameter int DEPTH = fas_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [fas_pkg::AGE_W-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [fas_pkg::AGE_W-1:0] o_rdata
);

    logic [fas_pkg::AGE_W-1:0] r_mem [DEPTH];
    logic [fas_pkg::AGE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/fas_div.sv -----
// Restoring divider, one quotient bit per cycle, for the fixed-point mean.
`default_nettype none
module fas_div #(
    parameter int DW = 32,
    parameter int VW = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [DW-1:0]              i_dividend,
    input  wire logic [VW-1:0]              i_divisor,
    output logic                            o_done,
    output logic      [fas_pkg::MEAN_W-1:0] o_quot
);

    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo[fas_pkg::MEAN_W-1:0];

endmodule
`default_nettype wire

// ----- tb/sv/fifo_with_age_statistics_checker.sv -----
// Checker for the age queue: predicts each reply from accepted requests and compares.
module fifo_with_age_statistics_checker #(
    parameter int QUEUE_DEPTH = fas_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // age[9:0], zero pad
    input  wire logic [2:0]  i_s_axis_tuser,   // mode[2:0]
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [31:0] i_m_axis_tdata,   // value[9:0], mean_q8[27:10], zero pad
    input  wire logic [1:0]  i_m_axis_tuser,   // status[1:0]
    output int               o_fail_count,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW     = fas_pkg::AGE_W;
    localparam int MW     = fas_pkg::MEAN_W;
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        fas_pkg::t_status status;
        logic [AW-1:0]    value;
        logic [MW-1:0]    mean_q8;
    } t_age_reply;

    logic [AW-1:0] age_slots [QUEUE_DEPTH];
    int            head_slot;
    int            tail_slot;
    int            held_count;
    t_age_reply    awaited_replies [$];
    int            fail_count;
    t_age_reply    want;

    // Applies one request to the shadow queue and returns the reply it should give.
    function automatic t_age_reply apply_request(input logic [2:0] mode,
                                                 input logic [AW-1:0] age);
        t_age_reply    r;
        logic [AW-1:0] hi;
        logic [AW-1:0] lo;
        logic [AW-1:0] cur;
        logic [31:0]   total;
        int            slot;
        r.status  = fas_pkg::STAT_OK;
        r.value   = '0;
        r.mean_q8 = '0;
        case (mode)
            fas_pkg::MODE_ENQ: begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.status = fas_pkg::STAT_FULL;
                end else begin
                    age_slots[SLOT_W'(tail_slot)] =
                        (age > fas_pkg::AGE_MAX) ? fas_pkg::AGE_MAX : age;
                    tail_slot  = (tail_slot + 1) % QUEUE_DEPTH;
                    held_count = held_count + 1;
                end
            end
            fas_pkg::MODE_DEQ, fas_pkg::MODE_MEAN, fas_pkg::MODE_MAX,
            fas_pkg::MODE_MIN, fas_pkg::MODE_RANGE: begin
                if (held_count == 0) begin
                    r.status = fas_pkg::STAT_EMPTY;
                end else if (mode == fas_pkg::MODE_DEQ) begin
                    r.value    = age_slots[SLOT_W'(head_slot)];
                    head_slot  = (head_slot + 1) % QUEUE_DEPTH;
                    held_count = held_count - 1;
                end else begin
                    hi    = '0;
                    lo    = fas_pkg::AGE_LIMIT;
                    total = '0;
                    slot  = head_slot;
                    for (int k = 0; k < held_count; k++) begin
                        cur   = age_slots[SLOT_W'(slot)];
                        total = total + 32'(cur);
                        if (cur > hi) hi = cur;
                        if (cur < lo) lo = cur;
                        slot = (slot + 1) % QUEUE_DEPTH;
                    end
                    case (mode)
                        fas_pkg::MODE_MEAN:
                            r.mean_q8 = MW'((total << fas_pkg::FRAC_W) / held_count);
                        fas_pkg::MODE_MAX:   r.value = hi;
                        fas_pkg::MODE_MIN:   r.value = lo;
                        default:             r.value = (hi >= lo) ? hi - lo : '0;
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot  = 0;
            tail_slot  = 0;
            held_count = 0;
            fail_count = 0;
            awaited_replies.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                awaited_replies.push_back(apply_request(i_s_axis_tuser,
                                                        i_s_axis_tdata[AW-1:0]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply word with no request pending: status %0d value %0d",
                           i_m_axis_tuser, i_m_axis_tdata[AW-1:0]);
                    fail_count = fail_count + 1;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                    if (i_m_axis_tdata[AW-1:0] !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value,
                               i_m_axis_tdata[AW-1:0]);
                        fail_count = fail_count + 1;
                    end
                    if (i_m_axis_tdata[AW +: MW] !== want.mean_q8) begin
                        $error("mean_q8: expected %0d, got %0d", want.mean_q8,
                               i_m_axis_tdata[AW +: MW]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= awaited_replies.size();
    end

endmodule

// ----- tb/sv/fifo_with_age_statistics_tb.sv -----
// Testbench top: drives requests and reply backpressure, reports the verdict.
module fifo_with_age_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH          = fas_pkg::QUEUE_DEPTH_DEF;
    localparam int         AW             = fas_pkg::AGE_W;
    localparam int         RANDOM_WORDS   = 2000;
    localparam int         SETTLE_CYCLES  = 120;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    typedef enum int { BURST_FILL, BURST_DRAIN, BURST_MIX } t_burst_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [15:0] req_data = '0;
    logic [2:0]  req_mode = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [31:0] rsp_data;
    logic [1:0]  rsp_status;
    int          fail_count;
    int          outstanding;
    bit          req_calm;
    bit          rsp_calm;

    always #1 clk = ~clk;

    fifo_with_age_statistics #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(req_valid),
        .o_s_axis_tready(req_ready),
        .i_s_axis_tdata (req_data),
        .i_s_axis_tuser (req_mode),
        .o_m_axis_tvalid(rsp_valid),
        .i_m_axis_tready(rsp_ready),
        .o_m_axis_tdata (rsp_data),
        .o_m_axis_tuser (rsp_status)
    );

    fifo_with_age_statistics_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(req_valid),
        .i_s_axis_tready(req_ready),
        .i_s_axis_tdata (req_data),
        .i_s_axis_tuser (req_mode),
        .i_m_axis_tvalid(rsp_valid),
        .i_m_axis_tready(rsp_ready),
        .i_m_axis_tdata (rsp_data),
        .i_m_axis_tuser (rsp_status),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [AW-1:0] draw_age();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return fas_pkg::AGE_MAX;
            2:       return AW'($urandom_range(fas_pkg::AGE_LIMIT, 1023));
            default: return AW'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [2:0] draw_mode(input t_burst_kind kind);
        int         r;
        int         enq_pct;
        int         deq_pct;
        logic [2:0] query;
        r     = $urandom_range(0, 99);
        query = 3'($urandom_range(fas_pkg::MODE_MEAN, fas_pkg::MODE_RANGE));
        case (kind)
            BURST_FILL:  begin enq_pct = 70; deq_pct = 10; end
            BURST_DRAIN: begin enq_pct = 15; deq_pct = 65; end
            default:     begin enq_pct = 35; deq_pct = 30; end
        endcase
        if (r < enq_pct) return fas_pkg::MODE_ENQ;
        if (r < enq_pct + deq_pct) return fas_pkg::MODE_DEQ;
        if (r < 98) return query;
        return (r == 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
    endfunction

    // Leaves valid high on return so a zero gap gives back-to-back words.
    task automatic send_word(input logic [2:0] mode, input logic [AW-1:0] age);
        int gap;
        if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
        gap = draw_gap(req_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_mode  <= mode;
        req_data  <= {6'd0, age};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic wait_all_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            gap = draw_gap(rsp_calm);
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial begin
        int          sent;
        int          burst_len;
        t_burst_kind kind;
        logic [2:0]  mode;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, spare modes
        send_word(fas_pkg::MODE_DEQ, 10'd5);
        send_word(fas_pkg::MODE_MEAN, 10'd0);
        send_word(fas_pkg::MODE_MAX, 10'd1023);
        send_word(fas_pkg::MODE_MIN, 10'd0);
        send_word(fas_pkg::MODE_RANGE, 10'd0);
        send_word(MODE_SPARE_LO, 10'd1023);
        send_word(MODE_SPARE_HI, 10'd0);
        // extremes and saturation
        send_word(fas_pkg::MODE_ENQ, 10'd0);
        send_word(fas_pkg::MODE_ENQ, 10'd1023);
        send_word(fas_pkg::MODE_ENQ, fas_pkg::AGE_MAX);
        send_word(fas_pkg::MODE_ENQ, fas_pkg::AGE_LIMIT);
        send_word(fas_pkg::MODE_MEAN, 10'd0);
        send_word(fas_pkg::MODE_MAX, 10'd0);
        send_word(fas_pkg::MODE_MIN, 10'd0);
        send_word(fas_pkg::MODE_RANGE, 10'd0);
        send_word(fas_pkg::MODE_DEQ, 10'd0);
        send_word(fas_pkg::MODE_DEQ, 10'd0);
        send_word(fas_pkg::MODE_ENQ, 10'h2AA);
        send_word(fas_pkg::MODE_ENQ, 10'h155);
        send_word(fas_pkg::MODE_RANGE, 10'd0);
        repeat (4) send_word(fas_pkg::MODE_DEQ, 10'd0);
        send_word(fas_pkg::MODE_DEQ, 10'd0);
        wait_all_replies();

        // fill past capacity, then query a full queue
        repeat (DEPTH + 4) send_word(fas_pkg::MODE_ENQ, draw_age());
        for (int m = fas_pkg::MODE_MEAN; m <= fas_pkg::MODE_RANGE; m++) begin
            send_word(3'(m), draw_age());
        end

        while (sent < RANDOM_WORDS) begin
            kind      = t_burst_kind'($urandom_range(0, 2));
            burst_len = $urandom_range(20, 80);
            repeat (burst_len) begin
                mode = draw_mode(kind);
                send_word(mode, draw_age());
                if (mode <= fas_pkg::MODE_RANGE) sent++;
            end
            if ($urandom_range(0, 7) == 0) wait_all_replies();
        end

        wait_all_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("fifo_with_age_statistics_tb: done, clean");
        end else begin
            $display("fifo_with_age_statistics_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("fifo_with_age_statistics_tb: done, errors");
        $finish;
    end

endmodule
